// ===== hdl/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types, constants and field lookups for the config frame deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

	// defaults for the top-level parameters
	localparam int MAX_FIELDS_DEF   = 8;
	localparam int WINDOW_BYTES_DEF = 35;
	localparam int RAM_DEPTH_DEF    = 64;

	// fields that have register bits
	localparam int FIELDS_CFG = 8;

	// field index as seen by the lookup functions
	localparam int FIDX_W = 4;

	// bytes-in-chunk counter, saturating
	localparam int                CNT_W   = 6;
	localparam logic [CNT_W-1:0]  CNT_MAX = '1;

	// history entry: running sum after the byte, then the last four bytes
	localparam int ENT_W = 8 + 32;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC   = 3'd0,
		REG_COUNT  = 3'd1,
		REG_SIZES  = 3'd2,
		REG_SIGNED = 3'd3,
		REG_SLOTS  = 3'd4
	} cfg_reg_t;

	localparam logic [15:0] SYNC_RST   = 16'hAA55;
	localparam logic [3:0]  COUNT_RST  = 4'd5;
	localparam logic [15:0] SIZES_RST  = 16'd340;
	localparam logic [7:0]  SIGNED_RST = 8'd22;
	localparam logic [31:0] SLOTS_RST  = 32'd344592;

	// per-field attributes carried alongside a field read
	typedef struct packed {
		logic [1:0] szm1;
		logic       sgn;
		logic [3:0] slot;
		logic       last;
	} fld_info_t;

	// byte count minus one; fields without register bits are one byte
	function automatic logic [1:0] fld_size_m1(input logic [15:0] sizes,
		input logic [FIDX_W-1:0] idx);
		logic [1:0] r;
		r = 2'd0;
		if (idx < FIDX_W'(FIELDS_CFG))
			r = sizes[{idx[2:0], 1'b0} +: 2];
		return r;
	endfunction

	function automatic logic fld_signed(input logic [7:0] sgn,
		input logic [FIDX_W-1:0] idx);
		logic r;
		r = 1'b0;
		if (idx < FIDX_W'(FIELDS_CFG))
			r = sgn[idx[2:0]];
		return r;
	endfunction

	function automatic logic [3:0] fld_slot(input logic [31:0] slots,
		input logic [FIDX_W-1:0] idx);
		logic [3:0] r;
		r = 4'd0;
		if (idx < FIDX_W'(FIELDS_CFG))
			r = slots[{idx[2:0], 2'b00} +: 4];
		return r;
	endfunction

endpackage

// ===== hdl/config_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// config_frame_deframer
// Sync-word / checksum frame parser over a chunked byte stream.
// ----------------------------------------------------------------------------
// Use:
//  Bytes come in on the byte channel (byte_valid / byte_stall), one per beat,
//  with chunk_end set on the last byte of a receive chunk. Results leave on
//  the result channel (res_valid / res_stall): one beat per decoded field of
//  the first good frame in a chunk, or a single not-found beat (found = 0)
//  when a chunk closes without one. last marks the final beat a byte causes.
//  Configuration is written through cfg_we / cfg_idx / cfg_data while idle.
// Flow:
//  One byte per cycle while no frame is found and no not-found beat is held
//  by res_stall; the check of each byte is one read of the history RAM. A good
//  frame gives one field per cycle unless res_stall holds it, each being one
//  RAM read, with the byte side stalled. Bytes reach results through stage 1,
//  then (for fields) the sequencer and RAM read, then the result register.
// Reset:
//  Control state and configuration registers reset at once; history RAM data
//  is left undefined and never used before being written in the current chunk,
//  so there is no clearing pass. A stalled receiver holds the result register;
//  the byte side keeps going until a second result would be needed.
// ----------------------------------------------------------------------------
module config_frame_deframer #(
	parameter int MAX_FIELDS   = cfd_pkg::MAX_FIELDS_DEF,
	parameter int WINDOW_BYTES = cfd_pkg::WINDOW_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [cfd_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [cfd_pkg::CFG_DATA_W-1:0]  cfg_data,
	// byte channel
	input  logic                            byte_valid,
	output logic                            byte_stall,
	input  logic [7:0]                      rx_byte,
	input  logic                            chunk_end,
	// result channel
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic                            found,
	output logic [3:0]                      slot,
	output logic signed [31:0]              value,
	output logic                            last
);

	// history RAM: one entry per byte, indexed by byte position mod DEPTH
	localparam int AW    = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
	localparam int DEPTH = 1 << AW;
	// field count and field index widths
	localparam int NW = $clog2(MAX_FIELDS + 1);
	localparam int FW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

	localparam int CW = cfd_pkg::CNT_W;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [15:0] sync_q;
	logic [3:0]  fcount_q;
	logic [15:0] fsizes_q;
	logic [7:0]  fsigned_q;
	logic [31:0] fslots_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q    <= cfd_pkg::SYNC_RST;
			fcount_q  <= cfd_pkg::COUNT_RST;
			fsizes_q  <= cfd_pkg::SIZES_RST;
			fsigned_q <= cfd_pkg::SIGNED_RST;
			fslots_q  <= cfd_pkg::SLOTS_RST;
		end else if (cfg_we) begin
			case (cfd_pkg::cfg_reg_t'(cfg_idx))
				cfd_pkg::REG_SYNC:   sync_q    <= cfg_data[15:0];
				cfd_pkg::REG_COUNT:  fcount_q  <= cfg_data[3:0];
				cfd_pkg::REG_SIZES:  fsizes_q  <= cfg_data[15:0];
				cfd_pkg::REG_SIGNED: fsigned_q <= cfg_data[7:0];
				cfd_pkg::REG_SLOTS:  fslots_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// fields in use: zero counts as one, saturate at MAX_FIELDS
	logic [NW-1:0] nf;
	always_comb begin
		if (fcount_q == 4'd0)
			nf = NW'(1);
		else if (32'(fcount_q) > 32'(MAX_FIELDS))
			nf = NW'(MAX_FIELDS);
		else
			nf = NW'(fcount_q);
	end

	// frame length: two sync bytes, the fields, the checksum byte
	logic [CW-1:0] flen;
	always_comb begin
		flen = CW'(3);
		for (int f = 0; f < MAX_FIELDS; f++) begin
			if (f < int'(nf))
				flen = flen + CW'(cfd_pkg::fld_size_m1(fsizes_q,
					cfd_pkg::FIDX_W'(f))) + CW'(1);
		end
	end

	logic frame_fits;
	assign frame_fits = (32'(flen) <= 32'(WINDOW_BYTES));

	// ------------------------------------------------------------------
	// byte intake (stage 0): history write and check read
	// ------------------------------------------------------------------
	logic          accept;
	logic [AW-1:0] wptr_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_inc;
	logic [7:0]    sum_q;
	logic [7:0]    sum_nx;
	logic [31:0]   last4_q;
	logic [31:0]   last4_nx;
	logic [AW-1:0] chk_addr;

	assign accept   = byte_valid && !byte_stall;
	assign sum_nx   = sum_q + rx_byte;
	assign last4_nx = {rx_byte, last4_q[31:8]};
	assign cnt_inc  = (cnt_q == cfd_pkg::CNT_MAX) ? cnt_q : cnt_q + CW'(1);
	// entry of the second sync byte: frame start plus one
	assign chk_addr = wptr_q - AW'(flen) + AW'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			wptr_q <= wptr_q + AW'(1);
			cnt_q  <= chunk_end ? '0 : cnt_inc;
		end
	end

	// running sum and last-four-bytes shifter; only differences of the sum matter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			last4_q <= '0;
		end else if (accept) begin
			sum_q   <= sum_nx;
			last4_q <= last4_nx;
		end
	end

	// ------------------------------------------------------------------
	// history RAM
	// ------------------------------------------------------------------
	logic                      ram_re;
	logic [AW-1:0]             ram_raddr;
	logic [cfd_pkg::ENT_W-1:0] ram_rdata;
	logic [7:0]                rd_sum;
	logic [31:0]               rd_w;
	logic                      issue;
	logic [AW-1:0]             fld_addr;

	assign ram_re    = accept || issue;
	assign ram_raddr = accept ? chk_addr : fld_addr;
	assign rd_sum    = ram_rdata[39:32];
	assign rd_w      = ram_rdata[31:0];

	cfd_ram #(
		.WIDTH (cfd_pkg::ENT_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (wptr_q),
		.wdata ({sum_nx, last4_nx}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// frame check (stage 1)
	// ------------------------------------------------------------------
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          end_s1;
	logic [CW-1:0] cnt_s1;
	logic [7:0]    sum_s1;
	logic [AW-1:0] wptr_s1;
	logic          taken_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
			end_s1  <= chunk_end;
			cnt_s1  <= cnt_inc;
			sum_s1  <= sum_q;
			wptr_s1 <= wptr_q;
		end
	end

	logic       sync_ok;
	logic [7:0] csum;
	logic       match;
	logic       nofind;
	logic       retire;
	logic       out_load;

	// rd_w[23:16] is the first sync byte, rd_w[31:24] the second;
	// frame sum = S(checksum-1) - S(second sync) + both sync bytes
	assign sync_ok = (rd_w[23:16] == sync_q[15:8]) && (rd_w[31:24] == sync_q[7:0]);
	assign csum    = sum_s1 - rd_sum + rd_w[23:16] + rd_w[31:24];
	assign match   = valid_s1 && !taken_q && frame_fits && (cnt_s1 >= flen) &&
		sync_ok && (csum == byte_s1);
	assign nofind  = valid_s1 && end_s1 && !taken_q && !match;
	assign retire  = valid_s1 && (!nofind || out_load);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			taken_q  <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (retire)
				valid_s1 <= 1'b0;
			if (retire) begin
				if (end_s1)
					taken_q <= 1'b0;
				else if (match)
					taken_q <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// field sequencer: one RAM read per field
	// ------------------------------------------------------------------
	logic                        emit_q;
	logic [FW-1:0]               fi_q;
	logic [AW-1:0]               fptr_q;
	logic [cfd_pkg::FIDX_W-1:0]  fi_ext;
	logic [1:0]                  cur_szm1;
	logic                        fi_last;
	logic                        valid_s2;
	cfd_pkg::fld_info_t          fld_s2;

	assign fi_ext   = cfd_pkg::FIDX_W'(fi_q);
	assign cur_szm1 = cfd_pkg::fld_size_m1(fsizes_q, fi_ext);
	assign fi_last  = ((NW'(fi_q) + NW'(1)) == nf);
	assign issue    = emit_q && (!valid_s2 || out_load);
	// the entry of a field's last byte holds the whole field in its top bytes
	assign fld_addr = fptr_q + AW'(cur_szm1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q   <= 1'b0;
			fi_q     <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (retire && match) begin
				emit_q <= 1'b1;
				fi_q   <= '0;
			end else if (issue) begin
				fi_q <= fi_q + FW'(1);
				if (fi_last)
					emit_q <= 1'b0;
			end
			if (issue)
				valid_s2 <= 1'b1;
			else if (out_load)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire && match)
			fptr_q <= wptr_s1 - AW'(flen) + AW'(3);	// first field byte
		else if (issue)
			fptr_q <= fptr_q + AW'(cur_szm1) + AW'(1);
		if (issue) begin
			fld_s2.szm1 <= cur_szm1;
			fld_s2.sgn  <= cfd_pkg::fld_signed(fsigned_q, fi_ext);
			fld_s2.slot <= cfd_pkg::fld_slot(fslots_q, fi_ext);
			fld_s2.last <= fi_last;
		end
	end

	// little-endian field, top bytes of the entry; sign bit is always bit 31
	logic        sg;
	logic [31:0] fval;
	assign sg = fld_s2.sgn & rd_w[31];
	always_comb begin
		case (fld_s2.szm1)
			2'd0:    fval = {{24{sg}}, rd_w[31:24]};
			2'd1:    fval = {{16{sg}}, rd_w[31:16]};
			2'd2:    fval = {{8{sg}}, rd_w[31:8]};
			default: fval = rd_w;
		endcase
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	logic        res_valid_q;
	logic        found_q;
	logic [3:0]  slot_q;
	logic [31:0] value_q;
	logic        last_q;

	assign out_load = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (out_load)
			res_valid_q <= valid_s2 || nofind;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (valid_s2) begin
				found_q <= 1'b1;
				slot_q  <= fld_s2.slot;
				value_q <= fval;
				last_q  <= fld_s2.last;
			end else begin
				found_q <= 1'b0;
				slot_q  <= 4'd0;
				value_q <= 32'd0;
				last_q  <= 1'b1;
			end
		end
	end

	// take a byte when no field is pending and stage 1 is free or leaves without starting a frame
	assign byte_stall = emit_q || valid_s2 || (valid_s1 && !(retire && !match));

	assign res_valid = res_valid_q;
	assign found     = found_q;
	assign slot      = slot_q;
	assign value     = value_q;
	assign last      = last_q;

endmodule

// ===== hdl/cfd_ram.sv =====
// ----------------------------------------------------------------------------
// cfd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cfd_ram #(
	parameter int WIDTH = cfd_pkg::ENT_W,
	parameter int DEPTH = cfd_pkg::RAM_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/cfd_checker.sv =====
// ----------------------------------------------------------------------------
// cfd_checker
// Port-level checks on the config frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module cfd_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_stall,
	input  logic               res_valid,
	input  logic               res_stall,
	input  logic               found,
	input  logic [3:0]         slot,
	input  logic signed [31:0] value,
	input  logic               last
);

	// a held result beat keeps its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable({found, slot, value, last}))
		else $error("result beat changed while stalled");

	// not-found beat is alone and empty
	a_nofind_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !found |-> last && (slot == 4'd0) && (value == 32'sd0))
		else $error("malformed not-found beat");

	// while a frame is still being emitted no byte is taken
	a_emit_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !last |-> byte_stall)
		else $error("byte taken during frame emission");

	// the beat after a non-final field is another field
	a_group_cont: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !last |=> !res_valid || found)
		else $error("field group broken by not-found beat");

endmodule

bind config_frame_deframer cfd_checker u_cfd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_stall (byte_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.found      (found),
	.slot       (slot),
	.value      (value),
	.last       (last)
);
